// ----- hdl/text_char_class_bitmaps_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the character class bitmap scanner
// Implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CHAR_CLASS_BITMAPS_MACROS_SVH
`define TEXT_CHAR_CLASS_BITMAPS_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TCCB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tccb check failed");
`define TCCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tccb check failed");
`else
`define TCCB_ASSERT_SAME(label, ante, cons)
`define TCCB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/tccb_pkg.sv -----
// ----------------------------------------------------------------------------
// tccb_pkg
// Shared constants, types and byte classification for the bitmap scanner.
// ----------------------------------------------------------------------------
package tccb_pkg;

  localparam int DEF_WORD_BITS    = 64;
  localparam int DEF_MAX_PATTERNS = 8;

  localparam int CH_W    = 4;
  localparam int IDX_W   = 16;
  localparam int CFG_I_W = 4;
  localparam int CHARS_W = 64;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_I_W-1:0] {
    CFG_PATTERN_CHARS = 4'd0,
    CFG_PATTERN_COUNT = 4'd1
  } cfg_reg_t;

  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_SQUOTE = 8'h27;
  localparam byte_t CH_RPAREN = 8'h29;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_PERIOD = 8'h2E;
  localparam byte_t CH_COLON  = 8'h3A;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_QUEST  = 8'h3F;
  localparam byte_t CH_BTICK  = 8'h60;
  localparam byte_t CH_UPPER_A = 8'h41;
  localparam byte_t CH_UPPER_Z = 8'h5A;
  localparam byte_t CASE_OFFSET = 8'd32;

  // control handed from the top level to every cell
  typedef struct packed {
    logic take;   // byte request accepted
    logic last;   // accepted byte closes the word
    logic load;   // move finished word into the output row
    logic shift;  // output row advances by one cell
  } cell_ctl_t;

  function automatic byte_t fold_case(input byte_t b);
    byte_t r;
    r = b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  // high bytes (bit 7 set) are excluded and never match
  function automatic logic is_punct(input byte_t b);
    logic r;
    r = 1'b0;
    if (!b[7]) begin
      r = (b <= CH_DQUOTE) || (b >= CH_SQUOTE && b <= CH_RPAREN) ||
          (b == CH_COMMA) || (b == CH_PERIOD) || (b == CH_COLON) ||
          (b == CH_SEMI) || (b == CH_QUEST) || (b == CH_BTICK);
    end
    return r;
  endfunction

endpackage

// ----- hdl/tccb_cell.sv -----
// ----------------------------------------------------------------------------
// tccb_cell
// One channel: accumulates the bitmap of the current word and holds one
// slot of the output row that shifts toward the head.
// ----------------------------------------------------------------------------
module tccb_cell
  import tccb_pkg::*;
#(
  parameter int  WORD_BITS = DEF_WORD_BITS,
  parameter bit  IS_PUNCT  = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic                 match,
  input  logic [WORD_BITS-1:0] bit_sel,
  input  logic [WORD_BITS-1:0] keep,
  input  logic [WORD_BITS-1:0] shift_in,
  output logic [WORD_BITS-1:0] slot
);

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] slot_r, slot_nxt;
  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] hit;

  always_comb begin
    base    = ctl.load ? '0 : acc_r;
    hit     = base | (match ? bit_sel : '0);
    acc_nxt = base;
    if (ctl.take) begin
      if (ctl.last) begin
        acc_nxt = IS_PUNCT ? (hit | ~keep) : (hit & keep);
      end else begin
        acc_nxt = hit;
      end
    end
    slot_nxt = slot_r;
    if (ctl.load) begin
      slot_nxt = acc_r;
    end else if (ctl.shift) begin
      slot_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;

endmodule

// ----- hdl/text_char_class_bitmaps.sv -----
// A word's bitmap is registered in the cells, loaded into the output row, then shifted out.
// Throughput: one byte per cycle while in_ready is high; one result per cycle while out_ready is high.
// Each word holds the cell row for its load and its npat+1 results; the byte
// after a word end waits until the row is free, so short words run slower.
// Reset (rst_n low, synchronous) clears bitmaps, counters, config and out_valid; not row slots or result data.
// ----------------------------------------------------------------------------
// text_char_class_bitmaps
// Character class bitmap scanner built as a row of per-channel cells.
// ----------------------------------------------------------------------------
module text_char_class_bitmaps
  import tccb_pkg::*;
#(
  parameter int WORD_BITS    = DEF_WORD_BITS,
  parameter int MAX_PATTERNS = DEF_MAX_PATTERNS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_final_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      out_channel,
  output logic [IDX_W-1:0]     out_word_index,
  output logic [WORD_BITS-1:0] out_bitmap,
  output logic                 out_run_end,
  output logic                 out_buffer_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_I_W-1:0]   cfg_index,
  input  logic [CHARS_W-1:0]   cfg_data
);

`include "text_char_class_bitmaps_macros.svh"

  localparam int POS_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int NCELL = MAX_PATTERNS + 1;

  logic [CHARS_W-1:0] pattern_chars_r;
  logic [CH_W-1:0]    pattern_count_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] word_cnt_r, word_cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r;
  logic             pend_fin_r;
  logic [CH_W-1:0]  sh_cnt_r, sh_cnt_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [IDX_W-1:0] sh_idx_r;
  logic             sh_fin_r;

  logic             out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]  out_channel_r;
  logic [IDX_W-1:0] out_word_index_r;
  logic [WORD_BITS-1:0] out_bitmap_r;
  logic             out_run_end_r;
  logic             out_buffer_end_r;

  cell_ctl_t            ctl;
  byte_t                low_byte;
  logic                 word_end;
  logic [CH_W-1:0]      npat;
  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_BITS-1:0] keep;
  logic [NCELL-1:0]     match_v;
  logic [WORD_BITS-1:0] slot_q [NCELL];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_chars_r <= '0;
      pattern_count_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PATTERN_CHARS: pattern_chars_r <= cfg_data;
        CFG_PATTERN_COUNT: pattern_count_r <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // byte classification
  assign low_byte = fold_case(in_text_byte);
  assign match_v[0] = is_punct(low_byte);

  for (genvar k = 1; k < NCELL; k++) begin : g_match
    assign match_v[k] = (pattern_chars_r[8*(k-1) +: 8] == low_byte);
  end

  assign bit_sel = WORD_BITS'(1) << pos_r;
  assign keep    = bit_sel | (bit_sel - WORD_BITS'(1));
  assign npat    = (pattern_count_r > CH_W'(MAX_PATTERNS)) ? CH_W'(MAX_PATTERNS)
                                                           : pattern_count_r;

  // control
  always_comb begin
    in_ready  = !pend_r || (sh_cnt_r == '0);
    ctl.take  = in_valid && in_ready;
    ctl.load  = pend_r && (sh_cnt_r == '0);
    ctl.shift = (sh_cnt_r != '0) && (!out_valid_r || out_ready);
    word_end  = (pos_r == POS_W'(WORD_BITS - 1)) || in_final_byte;
    ctl.last  = word_end;

    pos_nxt      = pos_r;
    word_cnt_nxt = word_cnt_r;
    pend_nxt     = pend_r;
    if (ctl.load) begin
      pend_nxt = 1'b0;
    end
    if (ctl.take) begin
      if (word_end) begin
        pos_nxt      = '0;
        word_cnt_nxt = in_final_byte ? '0 : word_cnt_r + IDX_W'(1);
        pend_nxt     = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end

    sh_cnt_nxt = sh_cnt_r;
    ch_nxt     = ch_r;
    if (ctl.load) begin
      sh_cnt_nxt = npat + CH_W'(1);
      ch_nxt     = '0;
    end else if (ctl.shift) begin
      sh_cnt_nxt = sh_cnt_r - CH_W'(1);
      ch_nxt     = ch_r + CH_W'(1);
    end

    out_valid_nxt = out_valid_r;
    if (ctl.shift) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      word_cnt_r  <= '0;
      pend_r      <= 1'b0;
      sh_cnt_r    <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      word_cnt_r  <= word_cnt_nxt;
      pend_r      <= pend_nxt;
      sh_cnt_r    <= sh_cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && word_end) begin
      pend_idx_r <= word_cnt_r;
      pend_fin_r <= in_final_byte;
    end
    if (ctl.load) begin
      sh_idx_r <= pend_idx_r;
      sh_fin_r <= pend_fin_r;
    end
    if (ctl.shift) begin
      out_channel_r    <= ch_r;
      out_word_index_r <= sh_idx_r;
      out_bitmap_r     <= slot_q[0];
      out_run_end_r    <= (sh_cnt_r == CH_W'(1));
      out_buffer_end_r <= sh_fin_r;
    end
  end

  // cell row
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [WORD_BITS-1:0] next_slot;
    if (k < NCELL - 1) begin : g_mid
      assign next_slot = slot_q[k+1];
    end else begin : g_tail
      assign next_slot = '0;
    end
    tccb_cell #(
      .WORD_BITS (WORD_BITS),
      .IS_PUNCT  (k == 0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .match    (match_v[k]),
      .bit_sel  (bit_sel),
      .keep     (keep),
      .shift_in (next_slot),
      .slot     (slot_q[k])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_word_index = out_word_index_r;
  assign out_bitmap     = out_bitmap_r;
  assign out_run_end    = out_run_end_r;
  assign out_buffer_end = out_buffer_end_r;

  `TCCB_ASSERT_NEXT(a_chan_seq, out_valid_r && out_ready && !out_run_end_r,
    out_valid_r && (out_channel_r == $past(out_channel_r) + CH_W'(1)))
  `TCCB_ASSERT_SAME(a_cnt_max, 1'b1, sh_cnt_r <= CH_W'(NCELL))
  `TCCB_ASSERT_NEXT(a_pend_hold, pend_r && !ctl.load, pend_r)
  `TCCB_ASSERT_SAME(a_first_chan, ctl.load && out_valid_r && out_ready,
    out_run_end_r)

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: character class bitmap scanner testbench
// Streams text buffers into the scanner under several pattern settings and
// checks every punctuation and pattern bitmap against a cycle-free predictor,
// with random input gaps and random back-pressure on the result channel.
// ----------------------------------------------------------------------------
module tb_top;
  import tccb_pkg::*;

  localparam int NPAT = DEF_MAX_PATTERNS;
  localparam int WBITS = DEF_WORD_BITS;
  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_I_W-1:0] CFG_IDX_SPARE_LO = 4'd2;
  localparam logic [CFG_I_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

  typedef struct {
    logic [CH_W-1:0]  channel;
    logic [IDX_W-1:0] word_index;
    logic [WBITS-1:0] bitmap;
    logic             run_end;
    logic             buffer_end;
  } bitmap_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_text_byte = 8'd0;
  logic               in_final_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CH_W-1:0]    out_channel;
  logic [IDX_W-1:0]   out_word_index;
  logic [WBITS-1:0]   out_bitmap;
  logic               out_run_end;
  logic               out_buffer_end;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_I_W-1:0] cfg_index = '0;
  logic [CHARS_W-1:0] cfg_data = '0;

  // predictor state
  logic [CHARS_W-1:0] pattern_chars_q = '0;
  logic [3:0]         pattern_count_q = '0;
  int unsigned        scan_slot = 0;
  logic [WBITS-1:0]   punct_acc = '0;
  logic [WBITS-1:0]   pattern_acc [NPAT];
  logic [IDX_W-1:0]   word_ctr = '0;
  bitmap_result_t     expected_bitmaps [$];
  bitmap_result_t     oldest;

  int errors = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  int stall_left = 0;

  text_char_class_bitmaps u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .out_word_index(out_word_index),
    .out_bitmap    (out_bitmap),
    .out_run_end   (out_run_end),
    .out_buffer_end(out_buffer_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int n = 0; n < NPAT; n++) pattern_acc[n] = '0;
  end

  function automatic void predict_bitmaps(input byte_t raw, input logic fin);
    byte_t            b;
    logic [WBITS-1:0] bitv;
    logic [WBITS-1:0] keep;
    int unsigned      filled;
    int               npat;
    bitmap_result_t   r;
    bitv = {{(WBITS-1){1'b0}}, 1'b1} << scan_slot;
    b = raw;
    if (raw >= CH_UPPER_A && raw <= CH_UPPER_Z) b = raw + CASE_OFFSET;
    if (b inside {[8'h00:CH_DQUOTE], [CH_SQUOTE:CH_RPAREN], CH_COMMA, CH_PERIOD,
                  CH_COLON, CH_SEMI, CH_QUEST, CH_BTICK})
      punct_acc |= bitv;
    for (int n = 0; n < NPAT; n++) begin
      if (pattern_chars_q[8*n +: 8] == b) pattern_acc[n] |= bitv;
    end
    filled = scan_slot + 1;
    if (filled < WBITS && !fin) begin
      scan_slot = filled;
      return;
    end
    keep = (filled >= WBITS) ? '1 : (({{(WBITS-1){1'b0}}, 1'b1} << filled) - 1'b1);
    npat = (pattern_count_q > NPAT) ? NPAT : pattern_count_q;
    for (int k = 0; k <= npat; k++) begin
      r.channel    = k[CH_W-1:0];
      r.word_index = word_ctr;
      r.bitmap     = (k == 0) ? (punct_acc | ~keep) : (pattern_acc[k-1] & keep);
      r.run_end    = (k == npat);
      r.buffer_end = fin;
      expected_bitmaps.push_back(r);
    end
    punct_acc = '0;
    for (int n = 0; n < NPAT; n++) pattern_acc[n] = '0;
    scan_slot = 0;
    word_ctr = fin ? '0 : word_ctr + 1'b1;
  endfunction

  // result side: random stall bursts on out_ready
  always @(posedge clk) begin
    if (out_stalls_on && stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bitmaps.size() == 0) begin
        $error("unexpected result: channel %0d word %0d", out_channel, out_word_index);
        errors++;
      end else begin
        oldest = expected_bitmaps.pop_front();
        results_seen++;
        if (out_channel !== oldest.channel) begin
          $error("channel: expected %0d, got %0d", oldest.channel, out_channel);
          errors++;
        end
        if (out_word_index !== oldest.word_index) begin
          $error("word_index: expected %0d, got %0d", oldest.word_index, out_word_index);
          errors++;
        end
        if (out_bitmap !== oldest.bitmap) begin
          $error("bitmap: expected %h, got %h", oldest.bitmap, out_bitmap);
          errors++;
        end
        if (out_run_end !== oldest.run_end) begin
          $error("run_end: expected %b, got %b", oldest.run_end, out_run_end);
          errors++;
        end
        if (out_buffer_end !== oldest.buffer_end) begin
          $error("buffer_end: expected %b, got %b", oldest.buffer_end, out_buffer_end);
          errors++;
        end
      end
    end
  end

  task automatic send_text_byte(input byte_t b, input logic fin);
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_bitmaps(b, fin);
    bytes_sent++;
  endtask

  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bitmaps.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [CHARS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PATTERN_CHARS: pattern_chars_q = data;
      CFG_PATTERN_COUNT: pattern_count_q = data[3:0];
      default: ;
    endcase
  endtask

  task automatic set_patterns(input logic [CHARS_W-1:0] chars, input logic [CHARS_W-1:0] count);
    drain_results(8);
    write_reg(CFG_PATTERN_CHARS, chars);
    write_reg(CFG_PATTERN_COUNT, count);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic byte_t pick_text_byte();
    byte_t p;
    case ($urandom_range(0, 4))
      0: begin
        p = pattern_chars_q[8*$urandom_range(0, NPAT-1) +: 8];
        if (p >= CH_UPPER_A + CASE_OFFSET && p <= CH_UPPER_Z + CASE_OFFSET &&
            $urandom_range(0, 1) == 1)
          p = p - CASE_OFFSET;
      end
      1: p = $urandom_range(0, CH_BTICK);
      2: p = $urandom_range(CH_UPPER_A, CH_UPPER_Z) + ($urandom_range(0, 1) ? CASE_OFFSET : 8'd0);
      3: p = $urandom_range(8'h80, 8'hFF);
      default: p = $urandom_range(0, 255);
    endcase
    return p;
  endfunction

  function automatic logic [CHARS_W-1:0] pick_pattern_chars();
    logic [CHARS_W-1:0] r;
    for (int n = 0; n < NPAT; n++) begin
      case ($urandom_range(0, 3))
        0: r[8*n +: 8] = $urandom_range(CH_UPPER_A, CH_UPPER_Z) + CASE_OFFSET;
        1: r[8*n +: 8] = $urandom_range(0, CH_BTICK);
        2: r[8*n +: 8] = $urandom_range(8'h80, 8'hFF);
        default: r[8*n +: 8] = $urandom_range(0, 255);
      endcase
    end
    return r;
  endfunction

  // reset config: no patterns, only the punctuation channel comes out
  task automatic test_reset_defaults();
    send_text_byte(CH_UPPER_A, 1'b0);
    send_text_byte(CH_PERIOD, 1'b1);
  endtask

  task automatic test_byte_classes();
    byte_t probe [] = '{8'h00, CH_DQUOTE, 8'h23, 8'h26, CH_SQUOTE, CH_RPAREN, 8'h2A,
                        CH_COMMA, CH_PERIOD, CH_COLON, CH_SEMI, CH_QUEST, CH_BTICK,
                        CH_UPPER_A, CH_UPPER_Z, 8'h40, 8'h5B, 8'h7F, 8'h80, 8'hFF, 8'h61};
    // patterns: a b . 0x80 0xFF 0x00 z ?
    set_patterns(64'h3F7A_00FF_802E_6261, 64'd8);
    foreach (probe[i]) send_text_byte(probe[i], i == probe.size() - 1);
    send_text_byte(8'h42, 1'b1);
  endtask

  task automatic test_config_edges();
    // count field above the pattern limit, upper data bits ignored
    set_patterns('1, 64'hFFFF_FFFF_FFFF_FFF9);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h61, 1'b1);
    drain_results(8);
    write_reg(CFG_IDX_SPARE_LO, '0);
    write_reg(CFG_IDX_SPARE_HI, '0);
    cfg_valid <= 1'b0;
    send_text_byte(8'hFF, 1'b1);
    set_patterns('0, 64'd15);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h78, 1'b1);
    set_patterns(pick_pattern_chars(), 64'd0);
    send_text_byte(8'h71, 1'b1);
  endtask

  // one full word without end mark, then a partial or full final word
  task automatic test_full_words();
    int len;
    len = WBITS + $urandom_range(1, WBITS);
    set_patterns(pick_pattern_chars(), $urandom_range(1, NPAT));
    for (int i = 0; i < len; i++) send_text_byte(pick_text_byte(), i == len - 1);
  endtask

  task automatic run_buffer_phase(input logic [CHARS_W-1:0] count, input int n_items);
    int sent;
    int len;
    set_patterns(pick_pattern_chars(), count);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) send_text_byte(pick_text_byte(), i == len - 1);
      sent += len;
      if (in_gaps_on && $urandom_range(0, 3) == 0) drain_results(0);
    end
  endtask

  task automatic test_random_buffers();
    run_buffer_phase(64'd8, 6);
    run_buffer_phase(64'd0, 6);
    run_buffer_phase($urandom_range(1, 7), 6);
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    run_buffer_phase($urandom_range(0, 15), 6);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_byte_classes();
    test_config_edges();
    test_full_words();
    test_random_buffers();
    drain_results(20);
    $display("Scanned %0d text bytes under %0d pattern settings", bytes_sent, settings_used);
    $display("Checked %0d bitmap results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tccb_pkg.sv
hdl/tccb_cell.sv
hdl/text_char_class_bitmaps.sv
test/tb_top.sv
